FILE: rtl/core/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types, constants and wiring tables for the LED matrix frame buffer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

  localparam int NUM_COLUMNS = 8;
  localparam int NUM_ROWS    = 12;
  localparam int COL_W       = 3;
  localparam int ROW_W       = 4;
  localparam int WORD_W      = 12;
  localparam int BYTE_W      = 8;
  localparam int OUT_WORD_W  = 16;
  localparam int FLUSH_BYTES = 1 + 2 * NUM_COLUMNS;
  localparam int CNT_W       = $clog2(FLUSH_BYTES);
  localparam int CMD_W       = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 8;

  localparam logic [BYTE_W-1:0] RAM_START = 8'h00;
  localparam logic [CNT_W-1:0]  LAST_IDX  = CNT_W'(FLUSH_BYTES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PIXEL = 3'd0,
    CMD_SET_COL   = 3'd1,
    CMD_SET_ROW   = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_INVERT    = 3'd4,
    CMD_FLUSH     = 3'd5
  } cmd_t;

  typedef logic [WORD_W-1:0] word_t;

  // controller -> datapath
  typedef struct packed {
    logic             exec;  // apply accepted buffer command
    logic             load;  // load output byte register
    logic [CNT_W-1:0] idx;   // byte position in the flush
  } dp_ctrl_t;

  // logical column -> physical column
  localparam logic [COL_W-1:0] COL_MAP [NUM_COLUMNS] =
    '{3'd2, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0};

  // buffer row -> bit position in the display word
  localparam logic [ROW_W-1:0] ROW_MAP [NUM_ROWS] =
    '{4'd7, 4'd6, 4'd3, 4'd2, 4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd11, 4'd10, 4'd9};

  function automatic logic [OUT_WORD_W-1:0] remap_word(input word_t w);
    logic [OUT_WORD_W-1:0] v;
    v = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      v[ROW_MAP[r]] = w[r];
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/lmfb_dp.sv
// ----------------------------------------------------------------------------
// lmfb_dp
// Frame buffer registers, command update logic and flush byte register.
// ----------------------------------------------------------------------------
module lmfb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lmfb_pkg::dp_ctrl_t                ctrl,
  input  logic [lmfb_pkg::CMD_W-1:0]        cmd,
  input  logic [lmfb_pkg::COL_W-1:0]        col_index,
  input  logic [lmfb_pkg::ROW_W-1:0]        row_index,
  input  logic                              pixel_on,
  input  logic [lmfb_pkg::WORD_W-1:0]       data_value,
  output logic [lmfb_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_last
);
  import lmfb_pkg::*;

  word_t                 fb_r   [NUM_COLUMNS];
  word_t                 fb_nxt [NUM_COLUMNS];
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic [CNT_W-1:0]      k;
  logic [COL_W-1:0]      sel_col;
  logic [OUT_WORD_W-1:0] wd;
  logic                  row_ok;

  assign row_ok = (row_index < ROW_W'(NUM_ROWS));

  always_comb begin
    fb_nxt = fb_r;
    if (ctrl.exec) begin
      unique case (cmd)
        CMD_SET_PIXEL: begin
          if (row_ok) fb_nxt[COL_MAP[col_index]][row_index] = pixel_on;
        end
        CMD_SET_COL: begin
          fb_nxt[COL_MAP[col_index]] = data_value;
        end
        CMD_SET_ROW: begin
          if (row_ok) begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
              fb_nxt[COL_MAP[c]][row_index] = data_value[c];
            end
          end
        end
        CMD_CLEAR: begin
          for (int c = 0; c < NUM_COLUMNS; c++) fb_nxt[c] = '0;
        end
        CMD_INVERT: begin
          for (int c = 0; c < NUM_COLUMNS; c++) fb_nxt[c] = ~fb_r[c];
        end
        default: ;  // flush and unused codes leave the buffer alone
      endcase
    end
  end

  // byte k+1 of the flush: column k/2, low byte first
  assign k       = ctrl.idx - CNT_W'(1);
  assign sel_col = k[COL_W:1];
  assign wd      = remap_word(fb_r[sel_col]);

  always_comb begin
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (ctrl.load) begin
      if (ctrl.idx == '0) byte_nxt = RAM_START;
      else if (k[0])      byte_nxt = wd[OUT_WORD_W-1:BYTE_W];
      else                byte_nxt = wd[BYTE_W-1:0];
      last_nxt = (ctrl.idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COLUMNS; c++) fb_r[c] <= '0;
    end else begin
      fb_r <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_byte = byte_r;
  assign out_last = last_r;

endmodule

FILE: rtl/core/lmfb_ctrl.sv
// ----------------------------------------------------------------------------
// lmfb_ctrl
// Command acceptance and flush sequencer: byte counter and output valid.
// ----------------------------------------------------------------------------
module lmfb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [lmfb_pkg::CMD_W-1:0]  in_cmd,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output lmfb_pkg::dp_ctrl_t          ctrl
);
  import lmfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SEND);
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl.exec = in_acc;
    ctrl.load = 1'b0;
    ctrl.idx  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_FLUSH) begin
          state_nxt = ST_SEND;
          cnt_nxt   = '0;
          ctrl.load = 1'b1;
        end
      end
      ST_SEND: begin
        if (out_acc) begin
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            ctrl.load = 1'b1;
            ctrl.idx  = cnt_nxt;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while flush in progress");

  a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_FLUSH) |=> (out_tvalid && cnt_r == '0))
    else $error("flush did not start at byte zero");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("byte counter out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && cnt_r != LAST_IDX) |=> (out_tvalid && cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("byte counter did not advance");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && cnt_r == LAST_IDX) |=> in_tready)
    else $error("flush did not return to idle");
`endif

endmodule

FILE: rtl/core/led_matrix_frame_buffer_core.sv
// Buffer commands (set pixel/column/row, clear, invert): one word per cycle outside a
// flush, applied at the accepting edge; no output words. Flush: 17 output words, the
// first valid in the cycle after acceptance, then one per cycle while out_tready is
// high; the input side stalls until the last byte is taken.
// Throughput is set by the flush byte counter in the controller.
// Reset (rst_n low, synchronous): frame buffer cleared to zeros, controller idle.
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer_core
// 8x12 LED frame buffer with column/row wiring remap and serialized flush.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] col_index, [6:3] row_index, [7] pixel_on, [19:8] data_value, [23:20] zero
  input  logic [lmfb_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] cmd
  input  logic [lmfb_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte
  output logic [lmfb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import lmfb_pkg::*;

  dp_ctrl_t ctrl;

  // Controller: accepts commands when idle, sequences the 17 flush bytes.
  lmfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  // Datapath: frame buffer, command updates, remapped output byte register.
  lmfb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cmd        (in_tuser),
    .col_index  (in_tdata[2:0]),
    .row_index  (in_tdata[6:3]),
    .pixel_on   (in_tdata[7]),
    .data_value (in_tdata[19:8]),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix frame buffer core.
// Drives buffer commands and flushes over the input stream, mirrors the
// 8x12 buffer with its column and row wiring, and checks each flushed byte
// and its end flag in order. Both stream sides idle at random. One long
// output hold-off backs the core up, and one sender pause drains it fully.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lmfb_pkg::*;

  // cmd codes the core has no use for; they must leave it untouched
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int ITEM_TARGET    = 185;
  localparam int HOLD_AT_ITEM   = 60;   // long receiver hold-off starts here
  localparam int DRAIN_AT_ITEM  = 140;  // sender waits for an empty core here
  localparam int CALM_AT_ITEM   = 160;  // no idling from here on
  localparam int RX_HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES  = 24;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } flush_byte_t;

  // --------------------------------------------------------------------------
  // Buffer mirror plus the queue of bytes a flush is due to send.
  // --------------------------------------------------------------------------
  class frame_tracker;
    logic [WORD_W-1:0] columns [NUM_COLUMNS];
    flush_byte_t       flush_q [$];
    int                failures;

    function new();
      foreach (columns[i]) columns[i] = '0;
      failures = 0;
    endfunction

    function int pending();
      return flush_q.size();
    endfunction

    // one accepted input word
    function void apply_cmd(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                            logic [ROW_W-1:0] row, logic on,
                            logic [WORD_W-1:0] data);
      logic [OUT_WORD_W-1:0] wired;
      flush_byte_t           fb;
      case (cmd)
        CMD_SET_PIXEL: begin
          if (row < NUM_ROWS) columns[COL_MAP[col]][row] = on;
        end
        CMD_SET_COL: begin
          columns[COL_MAP[col]] = data;
        end
        CMD_SET_ROW: begin
          // bit c of data is logical column c
          if (row < NUM_ROWS)
            for (int c = 0; c < NUM_COLUMNS; c++) columns[COL_MAP[c]][row] = data[c];
        end
        CMD_CLEAR: begin
          foreach (columns[i]) columns[i] = '0;
        end
        CMD_INVERT: begin
          foreach (columns[i]) columns[i] = ~columns[i];
        end
        CMD_FLUSH: begin
          fb.value = RAM_START;
          fb.last  = 1'b0;
          flush_q.push_back(fb);
          for (int p = 0; p < NUM_COLUMNS; p++) begin
            wired = '0;
            for (int r = 0; r < NUM_ROWS; r++) wired[ROW_MAP[r]] = columns[p][r];
            fb.value = wired[7:0];
            fb.last  = 1'b0;
            flush_q.push_back(fb);
            fb.value = wired[15:8];
            fb.last  = (p == NUM_COLUMNS - 1);
            flush_q.push_back(fb);
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted output word
    function void check_byte(logic [BYTE_W-1:0] value, logic last);
      flush_byte_t fb;
      if (flush_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected byte %02h last %0b", $realtime, value, last);
        return;
      end
      fb = flush_q.pop_front();
      if (fb.value !== value || fb.last !== last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                   $realtime, fb.value, fb.last, value, last);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  frame_tracker frames = new();

  bit rx_hold = 1'b0;  // sender asks the receiver for the long hold-off
  bit calm    = 1'b0;  // no idling on either side
  int cycle_count = 0;

  led_matrix_frame_buffer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [2:0] col, [6:3] row, [7] pixel_on, [19:8] data, [23:20] 0
    .in_tuser  (in_tuser),   // [2:0] cmd
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] out_byte
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the core hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // output monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) frames.check_byte(out_tdata, out_tlast);
  end

  // receiver: random stalls, one long hold-off on request, steady when calm
  initial begin
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until the core takes it; the mirror is
  // updated at the accepting edge, in acceptance order.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic on,
                           input logic [WORD_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, data, on, row, col};
    do @(posedge clk); while (!in_tready);
    frames.apply_cmd(cmd, col, row, on, data);
  endtask

  // random sender gap; tvalid only drops when the task then waits on the clock
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sender pause until the core has sent every byte owed
  task automatic drain_core();
    if (frames.pending() != 0) begin
      in_tvalid <= 1'b0;
      while (frames.pending() != 0) @(posedge clk);
    end
  endtask

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              on;
    logic [WORD_W-1:0] data;
    int                pick;
    int                n_eff;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: empty buffer, field extremes, every command ----
    send_word(CMD_FLUSH,     3'd0, 4'd0,  1'b0, 12'h000);  // flush of a cleared buffer
    send_word(CMD_SET_PIXEL, 3'd0, 4'd0,  1'b1, 12'h000);
    send_word(CMD_SET_PIXEL, 3'd7, 4'd11, 1'b1, 12'hFFF);
    send_word(CMD_SET_PIXEL, 3'd5, 4'd12, 1'b1, 12'h000);  // row past the end: ignored
    send_word(CMD_SET_PIXEL, 3'd2, 4'd15, 1'b1, 12'hFFF);  // row past the end: ignored
    send_word(CMD_FLUSH,     3'd7, 4'd15, 1'b1, 12'hFFF);
    send_word(CMD_SET_COL,   3'd3, 4'd0,  1'b0, 12'hFFF);
    send_word(CMD_SET_COL,   3'd7, 4'd9,  1'b1, 12'hA5A);
    send_word(CMD_SET_COL,   3'd0, 4'd0,  1'b0, 12'h000);
    send_word(CMD_SET_ROW,   3'd0, 4'd5,  1'b0, 12'hFFF);  // upper data bits unused
    send_word(CMD_SET_ROW,   3'd6, 4'd0,  1'b1, 12'h0C3);
    send_word(CMD_SET_ROW,   3'd1, 4'd13, 1'b0, 12'h0FF);  // row past the end: ignored
    send_word(CMD_FLUSH,     3'd0, 4'd0,  1'b0, 12'h000);
    send_word(CMD_INVERT,    3'd0, 4'd0,  1'b0, 12'h000);  // only 12 stored bits flip
    send_word(CMD_FLUSH,     3'd0, 4'd0,  1'b0, 12'h000);
    send_word(CMD_SET_PIXEL, 3'd3, 4'd4,  1'b0, 12'h000);
    send_word(CMD_SPARE_6,   3'd7, 4'd11, 1'b1, 12'hFFF);  // unused code: no effect
    send_word(CMD_SPARE_7,   3'd1, 4'd3,  1'b1, 12'h5A5);  // unused code: no effect
    send_word(CMD_FLUSH,     3'd0, 4'd0,  1'b0, 12'h000);
    send_word(CMD_CLEAR,     3'd5, 4'd7,  1'b1, 12'hFFF);
    send_word(CMD_FLUSH,     3'd0, 4'd0,  1'b0, 12'h000);

    // ---- random: mostly live commands, some out-of-range rows and spares ----
    n_eff = 0;
    while (n_eff < ITEM_TARGET) begin
      sender_gap();
      calm = (n_eff >= CALM_AT_ITEM);

      pick = $urandom_range(0, 99);
      if      (pick < 28) cmd = CMD_SET_PIXEL;
      else if (pick < 43) cmd = CMD_SET_COL;
      else if (pick < 58) cmd = CMD_SET_ROW;
      else if (pick < 62) cmd = CMD_CLEAR;
      else if (pick < 70) cmd = CMD_INVERT;
      else if (pick < 92) cmd = CMD_FLUSH;
      else if (pick < 96) cmd = CMD_SPARE_6;
      else                cmd = CMD_SPARE_7;

      col  = COL_W'($urandom_range(0, NUM_COLUMNS - 1));
      row  = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(NUM_ROWS, 15))
                                         : ROW_W'($urandom_range(0, NUM_ROWS - 1));
      on   = 1'($urandom_range(0, 1));
      data = WORD_W'($urandom_range(0, 4095));

      // back the core up: flush, then keep offering while the output is held
      if (n_eff == HOLD_AT_ITEM) begin
        cmd     = CMD_FLUSH;
        rx_hold = 1'b1;
      end

      // flush, then hold the input off until every byte of it is out
      if (n_eff == DRAIN_AT_ITEM) cmd = CMD_FLUSH;

      send_word(cmd, col, row, on, data);

      if (n_eff == DRAIN_AT_ITEM) drain_core();

      if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7 &&
          !((cmd == CMD_SET_PIXEL || cmd == CMD_SET_ROW) && row >= NUM_ROWS))
        n_eff++;
    end
    in_tvalid <= 1'b0;

    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (frames.failures == 0 && frames.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
